@@ hdl/trcm_pkg.sv @@
package trcm_pkg;

   localparam int ALPHABET_SIZE = 26;
   localparam int NUM_ROTORS    = 3;
   localparam int NUM_START     = 3;

   localparam int LETTER_W  = 5;
   localparam int SEL_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int ROT_W     = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
   localparam int ADDR_W    = (NUM_ROTORS * ALPHABET_SIZE > 1) ?
                              $clog2(NUM_ROTORS * ALPHABET_SIZE) : 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_FIRST  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_SECOND = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_START_THIRD  = CSR_IDX_W'(2);

   // table select codes
   localparam logic [SEL_W-1:0] SEL_REFLECTOR = SEL_W'(NUM_ROTORS);
   localparam logic [SEL_W-1:0] SEL_PLUGBOARD = SEL_W'(NUM_ROTORS + 1);

   localparam logic [ROT_W-1:0] LAST_ROTOR = ROT_W'(NUM_ROTORS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLUG_IN,
      ST_FWD_READ,
      ST_FWD_WB,
      ST_REFLECT,
      ST_BWD_READ,
      ST_BWD_WB,
      ST_PLUG_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_PLUG,
      DP_ROT_READ,
      DP_ROT_WB,
      DP_REFLECT,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic             backward;
      logic [ROT_W-1:0] rotor;
   } dp_cmd_type;

   // reduce a letter code below the alphabet size (value below twice the size)
   function automatic logic [LETTER_W-1:0] reduce_letter(input logic [LETTER_W-1:0] v);
      logic [LETTER_W:0] t;
      t = {1'b0, v};
      if (t >= (LETTER_W+1)'(ALPHABET_SIZE)) begin
         t = t - (LETTER_W+1)'(ALPHABET_SIZE);
      end
      return t[LETTER_W-1:0];
   endfunction

   function automatic logic [LETTER_W-1:0] add_mod(input logic [LETTER_W-1:0] a,
                                                   input logic [LETTER_W-1:0] b);
      logic [LETTER_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= (LETTER_W+1)'(ALPHABET_SIZE)) begin
         t = t - (LETTER_W+1)'(ALPHABET_SIZE);
      end
      return t[LETTER_W-1:0];
   endfunction

   function automatic logic [LETTER_W-1:0] sub_mod(input logic [LETTER_W-1:0] a,
                                                   input logic [LETTER_W-1:0] b);
      logic [LETTER_W:0] t;
      t = {1'b0, a} + (LETTER_W+1)'(ALPHABET_SIZE) - {1'b0, b};
      if (t >= (LETTER_W+1)'(ALPHABET_SIZE)) begin
         t = t - (LETTER_W+1)'(ALPHABET_SIZE);
      end
      return t[LETTER_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] rotor_addr(input logic [ROT_W-1:0] rotor,
                                                    input logic [LETTER_W-1:0] idx);
      return ADDR_W'(rotor) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(idx);
   endfunction

endpackage

@@ hdl/three_rotor_cipher_machine_top.sv @@
// Three-rotor letter cipher with loadable rotor, reflector and plugboard tables.
// Load words give no result, and req_ready stays high after one is taken.
// Letter words pass plugboard, rotors forward, reflector, rotors back and plugboard
// (one registered read, then one add, per rotor pass); rsp_valid marks the result.
// Loads are taken one per cycle while no letter is in process.
// Reset (synchronous, active high): positions and start registers zero,
// plugboard identity; rotor and reflector tables hold garbage until loaded.
module three_rotor_cipher_machine_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_letter,
   input  logic                              req_restart,
   input  logic [trcm_pkg::SEL_W-1:0]        req_table_select,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_entry_index,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_entry_value,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [trcm_pkg::LETTER_W-1:0]     rsp_cipher_letter,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [trcm_pkg::LETTER_W-1:0]     csr_data
);
   import trcm_pkg::*;

   dp_cmd_type cmd;

   // start position registers take a word every cycle
   assign csr_ready = 1'b1;

   // sequencer: walks plugboard, rotors forward, reflector, rotors back,
   // plugboard; holds the last step while a result still waits downstream
   trcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // tables, positions, letter register and result register
   trcm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_letter       (req_letter),
      .req_restart      (req_restart),
      .req_table_select (req_table_select),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cipher_letter    (rsp_cipher_letter)
   );

endmodule

@@ hdl/trcm_ctrl.sv @@
module trcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output trcm_pkg::dp_cmd_type cmd
);
   import trcm_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [ROT_W-1:0] rot_ff, rot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             finish;

   // in the last step with the result slot free or being emptied this cycle
   assign finish = (state_ff == ST_PLUG_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      rot_in   = rot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_kind) begin
               state_in = ST_PLUG_IN;
            end
         end
         ST_PLUG_IN: begin
            state_in = ST_FWD_READ;
            rot_in   = '0;
         end
         ST_FWD_READ: state_in = ST_FWD_WB;
         ST_FWD_WB: begin
            if (rot_ff == LAST_ROTOR) begin
               state_in = ST_REFLECT;
            end else begin
               rot_in   = rot_ff + ROT_W'(1);
               state_in = ST_FWD_READ;
            end
         end
         ST_REFLECT: begin
            state_in = ST_BWD_READ;
            rot_in   = LAST_ROTOR;
         end
         ST_BWD_READ: state_in = ST_BWD_WB;
         ST_BWD_WB: begin
            if (rot_ff == '0) begin
               state_in = ST_PLUG_OUT;
            end else begin
               rot_in   = rot_ff - ROT_W'(1);
               state_in = ST_BWD_READ;
            end
         end
         ST_PLUG_OUT: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = DP_NOP;
      cmd.backward = 1'b0;
      cmd.rotor    = rot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_ACCEPT;
            end
         end
         ST_PLUG_IN:  cmd.op = DP_PLUG;
         ST_FWD_READ: cmd.op = DP_ROT_READ;
         ST_FWD_WB:   cmd.op = DP_ROT_WB;
         ST_REFLECT:  cmd.op = DP_REFLECT;
         ST_BWD_READ: begin
            cmd.op       = DP_ROT_READ;
            cmd.backward = 1'b1;
         end
         ST_BWD_WB:   cmd.op = DP_ROT_WB;
         ST_PLUG_OUT: begin
            if (finish) begin
               cmd.op = DP_FINISH;
            end
         end
         default: cmd.op = DP_NOP;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/trcm_dpath.sv @@
module trcm_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  trcm_pkg::dp_cmd_type              cmd,
   input  logic                              req_kind,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_letter,
   input  logic                              req_restart,
   input  logic [trcm_pkg::SEL_W-1:0]        req_table_select,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_entry_index,
   input  logic [trcm_pkg::LETTER_W-1:0]     req_entry_value,
   input  logic                              csr_write,
   input  logic [trcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [trcm_pkg::LETTER_W-1:0]     csr_data,
   output logic [trcm_pkg::LETTER_W-1:0]     cipher_letter
);
   import trcm_pkg::*;

   localparam int DEPTH = NUM_ROTORS * ALPHABET_SIZE;

   logic [LETTER_W-1:0] wiring_mem  [DEPTH];
   logic [LETTER_W-1:0] inverse_mem [DEPTH];
   logic [LETTER_W-1:0] refl_ff     [ALPHABET_SIZE];
   logic [LETTER_W-1:0] plug_ff     [ALPHABET_SIZE];
   logic [LETTER_W-1:0] pos_ff      [NUM_ROTORS];
   logic [LETTER_W-1:0] pos_in      [NUM_ROTORS];
   logic [LETTER_W-1:0] start_ff    [NUM_START];

   logic [LETTER_W-1:0] c_ff, c_in;
   logic [LETTER_W-1:0] rdata_ff;
   logic [LETTER_W-1:0] cipher_ff;

   logic                load_en, load_rotor, load_refl, load_plug;
   logic [LETTER_W-1:0] load_val;
   logic [LETTER_W-1:0] cur_pos;
   logic [ADDR_W-1:0]   read_addr;
   logic [ROT_W-1:0]    load_rot;

   assign load_en    = (cmd.op == DP_ACCEPT) && req_kind &&
                       ({1'b0, req_entry_index} < (LETTER_W+1)'(ALPHABET_SIZE));
   assign load_rotor = load_en && (req_table_select < SEL_REFLECTOR);
   assign load_refl  = load_en && (req_table_select == SEL_REFLECTOR);
   assign load_plug  = load_en && (req_table_select == SEL_PLUGBOARD);
   assign load_val   = reduce_letter(req_entry_value);
   assign load_rot   = ROT_W'(req_table_select);

   assign cur_pos   = pos_ff[cmd.rotor];
   assign read_addr = rotor_addr(cmd.rotor, sub_mod(c_ff, cur_pos));

   // rotor tables: one write per memory, registered read
   always_ff @(posedge clock) begin
      if (load_rotor) begin
         wiring_mem[rotor_addr(load_rot, req_entry_index)] <= load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rotor) begin
         inverse_mem[rotor_addr(load_rot, load_val)] <= req_entry_index;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_ROT_READ) begin
         if (cmd.backward) begin
            rdata_ff <= inverse_mem[read_addr];
         end else begin
            rdata_ff <= wiring_mem[read_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_refl) begin
         refl_ff[req_entry_index] <= load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            plug_ff[i] <= LETTER_W'(i);
         end
      end else if (load_plug) begin
         plug_ff[req_entry_index] <= load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_START; i++) begin
            start_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_FIRST:  start_ff[0] <= csr_data;
            CSR_START_SECOND: start_ff[1] <= csr_data;
            CSR_START_THIRD:  start_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // positions: reload on restart, odometer step after each letter
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int r = 0; r < NUM_ROTORS; r++) begin
         pos_in[r] = pos_ff[r];
      end
      if (cmd.op == DP_ACCEPT && !req_kind && req_restart) begin
         for (int r = 0; r < NUM_ROTORS; r++) begin
            pos_in[r] = (r < NUM_START) ? reduce_letter(start_ff[r]) : '0;
         end
      end else if (cmd.op == DP_FINISH) begin
         for (int r = 0; r < NUM_ROTORS; r++) begin
            if (carry) begin
               if ({1'b0, pos_ff[r]} + (LETTER_W+1)'(1) <
                   (LETTER_W+1)'(ALPHABET_SIZE)) begin
                  pos_in[r] = pos_ff[r] + LETTER_W'(1);
                  carry     = 1'b0;
               end else begin
                  pos_in[r] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROTORS; r++) begin
            pos_ff[r] <= '0;
         end
      end else begin
         for (int r = 0; r < NUM_ROTORS; r++) begin
            pos_ff[r] <= pos_in[r];
         end
      end
   end

   always_comb begin
      c_in = c_ff;
      unique case (cmd.op)
         DP_ACCEPT:   c_in = reduce_letter(req_letter);
         DP_PLUG:     c_in = plug_ff[c_ff];
         DP_ROT_WB:   c_in = add_mod(rdata_ff, cur_pos);
         DP_REFLECT:  c_in = refl_ff[c_ff];
         DP_NOP, DP_ROT_READ, DP_FINISH: c_in = c_ff;
         default:     c_in = c_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      if (cmd.op == DP_FINISH) begin
         cipher_ff <= plug_ff[c_ff];
      end
   end

   assign cipher_letter = cipher_ff;

endmodule

@@ sim/three_rotor_cipher_machine_checker.sv @@
`timescale 1ns / 1ps

module three_rotor_cipher_machine_checker (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_kind,
   input  logic [trcm_pkg::LETTER_W-1:0]  req_letter,
   input  logic                           req_restart,
   input  logic [trcm_pkg::SEL_W-1:0]     req_table_select,
   input  logic [trcm_pkg::LETTER_W-1:0]  req_entry_index,
   input  logic [trcm_pkg::LETTER_W-1:0]  req_entry_value,

   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [trcm_pkg::LETTER_W-1:0]  rsp_cipher_letter,

   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [trcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [trcm_pkg::LETTER_W-1:0]  csr_data,

   output int unsigned                    mismatch_count,
   output int unsigned                    letters_in_flight
);
   import trcm_pkg::*;

   typedef logic [LETTER_W-1:0] letter_type;

   letter_type start_position [NUM_START];
   letter_type wiring         [NUM_ROTORS][ALPHABET_SIZE];
   letter_type inverse        [NUM_ROTORS][ALPHABET_SIZE];
   letter_type reflector      [ALPHABET_SIZE];
   letter_type plugboard      [ALPHABET_SIZE];
   letter_type position       [NUM_ROTORS];
   letter_type expected_letters [$];

   int unsigned mismatches = 0;
   int unsigned in_flight  = 0;

   assign mismatch_count    = mismatches;
   assign letters_in_flight = in_flight;

   function automatic letter_type pass_rotor(input letter_type c, input int r,
                                             input bit backward);
      int unsigned shift;
      int unsigned slot;
      letter_type  v;
      shift = position[r];
      slot  = (c + ALPHABET_SIZE - shift) % ALPHABET_SIZE;
      v     = backward ? inverse[r][slot] : wiring[r][slot];
      return letter_type'((v + shift) % ALPHABET_SIZE);
   endfunction

   function automatic letter_type encipher_letter(input letter_type plain);
      letter_type c;
      c = plugboard[plain % ALPHABET_SIZE];
      for (int r = 0; r < NUM_ROTORS; r++) begin
         c = pass_rotor(c, r, 1'b0);
      end
      c = reflector[c % ALPHABET_SIZE];
      for (int r = NUM_ROTORS - 1; r >= 0; r--) begin
         c = pass_rotor(c, r, 1'b1);
      end
      return plugboard[c % ALPHABET_SIZE];
   endfunction

   // odometer: carry into the next rotor only on wrap
   function automatic void step_positions();
      for (int r = 0; r < NUM_ROTORS; r++) begin
         if (position[r] < ALPHABET_SIZE - 1) begin
            position[r] = position[r] + 1'b1;
            return;
         end
         position[r] = '0;
      end
   endfunction

   function automatic void reload_positions();
      for (int r = 0; r < NUM_ROTORS; r++) begin
         position[r] = (r < NUM_START) ?
                       letter_type'(start_position[r] % ALPHABET_SIZE) : '0;
      end
   endfunction

   function automatic void load_entry(input logic [SEL_W-1:0] sel, input letter_type slot,
                                      input letter_type raw_value);
      letter_type v;
      v = letter_type'(raw_value % ALPHABET_SIZE);
      if (slot >= ALPHABET_SIZE) begin
         return;
      end
      if (sel < NUM_ROTORS) begin
         wiring[sel][slot] = v;
         inverse[sel][v]   = slot;
      end else if (sel == SEL_REFLECTOR) begin
         reflector[slot] = v;
      end else if (sel == SEL_PLUGBOARD) begin
         plugboard[slot] = v;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      letter_type want;
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            plugboard[i] = letter_type'(i);
            reflector[i] = '0;
            for (int r = 0; r < NUM_ROTORS; r++) begin
               wiring[r][i]  = '0;
               inverse[r][i] = '0;
            end
         end
         for (int r = 0; r < NUM_ROTORS; r++) begin
            position[r] = '0;
         end
         for (int k = 0; k < NUM_START; k++) begin
            start_position[k] = '0;
         end
         expected_letters.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_FIRST:  start_position[0] = csr_data;
               CSR_START_SECOND: start_position[1] = csr_data;
               CSR_START_THIRD:  start_position[2] = csr_data;
               default: ;
            endcase
         end
         // retire the oldest letter before queuing one accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_letters.size() == 0) begin
               mismatches++;
               $display("%0t: cipher_letter expected none, actual %0d",
                        $time, rsp_cipher_letter);
            end else begin
               want = expected_letters.pop_front();
               if (rsp_cipher_letter !== want) begin
                  mismatches++;
                  $display("%0t: cipher_letter expected %0d, actual %0d",
                           $time, want, rsp_cipher_letter);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind) begin
               load_entry(req_table_select, req_entry_index, req_entry_value);
            end else begin
               if (req_restart) begin
                  reload_positions();
               end
               expected_letters.push_back(encipher_letter(req_letter));
               step_positions();
            end
         end
      end
      in_flight = expected_letters.size();
   end

endmodule

@@ sim/three_rotor_cipher_machine_top_tb.sv @@
`timescale 1ns / 1ps

module three_rotor_cipher_machine_top_tb;
   import trcm_pkg::*;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [SEL_W-1:0]    sel_type;

   localparam logic                 KIND_LETTER  = 1'b0;
   localparam logic                 KIND_LOAD    = 1'b1;
   // index past the start registers: the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = CSR_IDX_W'(NUM_START);
   localparam sel_type              SEL_UNUSED_LO = SEL_PLUGBOARD + 1'b1;
   localparam sel_type              SEL_UNUSED_HI = '1;
   // margin after the last outstanding letter comes out
   localparam int                   DRAIN_CYCLES = 24;
   localparam int                   PHASES       = 4;
   localparam int                   PHASE_WORDS  = 230;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_kind         = 1'b0;
   letter_type           req_letter       = '0;
   logic                 req_restart      = 1'b0;
   sel_type              req_table_select = '0;
   letter_type           req_entry_index  = '0;
   letter_type           req_entry_value  = '0;
   logic                 rsp_ready        = 1'b0;
   logic                 csr_valid        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   letter_type           csr_data         = '0;

   logic                 req_ready;
   logic                 rsp_valid;
   letter_type           rsp_cipher_letter;
   logic                 csr_ready;

   int unsigned mismatch_count;
   int unsigned letters_in_flight;

   // quiet stretches: no gaps on the request side, no new stalls on the response side
   bit          quiet_req  = 1'b0;
   bit          quiet_rsp  = 1'b0;
   int unsigned stall_left = 0;
   int unsigned rsp_cycle  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   three_rotor_cipher_machine_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_letter        (req_letter),
      .req_restart       (req_restart),
      .req_table_select  (req_table_select),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cipher_letter (rsp_cipher_letter),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   three_rotor_cipher_machine_checker cipher_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_letter        (req_letter),
      .req_restart       (req_restart),
      .req_table_select  (req_table_select),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cipher_letter (rsp_cipher_letter),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .letters_in_flight (letters_in_flight)
   );

   // Response back-pressure: mostly short stalls, now and then a long one,
   // and every so often a quiet window in which no new stall starts.
   always @(posedge clock) begin : rsp_backpressure
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % 256 == 0) begin
         quiet_rsp <= ($urandom_range(3) == 0);
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet_rsp && $urandom_range(99) < 18) begin
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Gap before the next request word: mostly none or short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_req) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 50) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(3, 1);
      end
      if (roll < 97) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(40, 13);
   endfunction

   // Start position: favor the extremes and the out-of-range codes.
   function automatic letter_type pick_start();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         return '0;
      end
      if (roll < 30) begin
         return letter_type'(ALPHABET_SIZE - 1);
      end
      if (roll < 40) begin
         return letter_type'($urandom_range(31, ALPHABET_SIZE));
      end
      return letter_type'($urandom_range(ALPHABET_SIZE - 1));
   endfunction

   function automatic void shuffle_letters(output letter_type perm [ALPHABET_SIZE]);
      letter_type  hold;
      int unsigned j;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         perm[i] = letter_type'(i);
      end
      for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
         j       = $urandom_range(i);
         hold    = perm[i];
         perm[i] = perm[j];
         perm[j] = hold;
      end
   endfunction

   // Present one request word and hold it until accepted. Called at a rising
   // edge; with no gap, valid simply stays high into the next word.
   task automatic send_word(input logic kind, input letter_type letter, input logic restart,
                            input sel_type sel, input letter_type slot,
                            input letter_type value);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_letter       <= letter;
      req_restart      <= restart;
      req_table_select <= sel;
      req_entry_index  <= slot;
      req_entry_value  <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Fill the fields the word does not use with noise so every bit toggles.
   task automatic send_letter(input letter_type letter, input logic restart);
      send_word(KIND_LETTER, letter, restart, sel_type'($urandom_range(7)),
                letter_type'($urandom_range(31)), letter_type'($urandom_range(31)));
   endtask

   task automatic send_load(input sel_type sel, input letter_type slot,
                            input letter_type value);
      send_word(KIND_LOAD, letter_type'($urandom_range(31)), 1'($urandom_range(1)),
                sel, slot, value);
   endtask

   // A full permutation leaves every forward and inverse entry written.
   task automatic load_rotor(input int r);
      letter_type perm [ALPHABET_SIZE];
      shuffle_letters(perm);
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         send_load(sel_type'(r), letter_type'(i), perm[i]);
      end
   endtask

   // Pair the shuffled letters up so the reflector is an involution.
   task automatic load_reflector();
      letter_type perm [ALPHABET_SIZE];
      shuffle_letters(perm);
      for (int k = 0; k < ALPHABET_SIZE / 2; k++) begin
         send_load(SEL_REFLECTOR, perm[2*k], perm[2*k+1]);
         send_load(SEL_REFLECTOR, perm[2*k+1], perm[2*k]);
      end
   endtask

   // Drop valid, wait for every outstanding letter, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (letters_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the three start registers back to back; optionally hit the unused index.
   task automatic program_start(input letter_type first, input letter_type second,
                                input letter_type third, input bit touch_unused);
      logic [CSR_IDX_W-1:0] index [NUM_START + 1];
      letter_type           data  [NUM_START + 1];
      int                   count;
      index = '{CSR_START_FIRST, CSR_START_SECOND, CSR_START_THIRD, CSR_UNUSED};
      data  = '{first, second, third, letter_type'($urandom_range(31))};
      count = touch_unused ? NUM_START + 1 : NUM_START;
      for (int k = 0; k < count; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index[k];
         csr_data  <= data[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 62) begin
         send_letter(($urandom_range(9) == 0) ?
                     letter_type'($urandom_range(31, ALPHABET_SIZE)) :
                     letter_type'($urandom_range(ALPHABET_SIZE - 1)),
                     ($urandom_range(19) == 0));
      end else begin
         send_load(($urandom_range(9) == 0) ? sel_type'($urandom_range(7, NUM_ROTORS + 2))
                                            : sel_type'($urandom_range(NUM_ROTORS + 1)),
                   ($urandom_range(9) == 0) ? letter_type'($urandom_range(31, ALPHABET_SIZE))
                                            : letter_type'($urandom_range(ALPHABET_SIZE - 1)),
                   letter_type'($urandom_range(31)));
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Start positions while idle, plus one write the block should ignore.
      program_start(letter_type'(3), letter_type'(7), letter_type'(11), 1'b1);

      // Wire every rotor and the reflector before the first letter goes in.
      for (int r = 0; r < NUM_ROTORS; r++) begin
         load_rotor(r);
      end
      load_reflector();

      // Letter extremes, the first one restarting from the start registers;
      // codes past Z wrap around the alphabet.
      send_letter(letter_type'(0), 1'b1);
      send_letter(letter_type'(ALPHABET_SIZE - 1), 1'b0);
      send_letter(letter_type'(ALPHABET_SIZE), 1'b0);
      send_letter('1, 1'b0);

      // Plug a symmetric pair, then a one-sided plug.
      send_load(SEL_PLUGBOARD, letter_type'(0), letter_type'(ALPHABET_SIZE - 1));
      send_load(SEL_PLUGBOARD, letter_type'(ALPHABET_SIZE - 1), letter_type'(0));
      send_letter(letter_type'(0), 1'b0);
      send_letter(letter_type'(ALPHABET_SIZE - 1), 1'b0);
      send_load(SEL_PLUGBOARD, letter_type'(7), letter_type'(12));
      send_letter(letter_type'(7), 1'b0);
      send_letter(letter_type'(12), 1'b0);

      // Loads that must be dropped: index past the alphabet, unused selects.
      send_load(SEL_PLUGBOARD, letter_type'(ALPHABET_SIZE), letter_type'(3));
      send_load(SEL_REFLECTOR, '1, letter_type'(0));
      send_load(SEL_UNUSED_LO, letter_type'(4), letter_type'(9));
      send_load(SEL_UNUSED_HI, letter_type'(5), letter_type'(2));

      // Restart on a load is ignored; an oversized value wraps and the rotor
      // stops being a permutation.
      send_word(KIND_LOAD, letter_type'(0), 1'b1, sel_type'(0), letter_type'(5), '1);
      send_letter(letter_type'(5), 1'b0);
      send_letter(letter_type'(9), 1'b0);

      // All rotors at the last position: the next step wraps everything.
      wait_idle();
      program_start(letter_type'(ALPHABET_SIZE - 1), letter_type'(ALPHABET_SIZE - 1),
                    letter_type'(ALPHABET_SIZE - 1), 1'b0);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b1);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b0);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b0);

      // Start codes past the alphabet reduce on restart.
      wait_idle();
      program_start(letter_type'(31), letter_type'(ALPHABET_SIZE), letter_type'(30), 1'b0);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b1);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b0);

      wait_idle();
      program_start('0, '0, '0, 1'b0);
      send_letter(letter_type'($urandom_range(ALPHABET_SIZE - 1)), 1'b1);

      // Random phases: new start registers, a fresh table, then mixed words.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         program_start(pick_start(), pick_start(), pick_start(), (p == 0));
         if ($urandom_range(NUM_ROTORS) == NUM_ROTORS) begin
            load_reflector();
         end else begin
            load_rotor($urandom_range(NUM_ROTORS - 1));
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) begin
               quiet_req = ($urandom_range(4) == 0);
            end
            send_random_word();
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
